FILE: hdl/aes_sbox_forward_inverse_assert.svh
// Assertion macros shared by the substitution block.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef AES_SBOX_FORWARD_INVERSE_ASSERT_SVH
`define AES_SBOX_FORWARD_INVERSE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, or after a fixed delay.
`define SBX_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("sbox assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error("sbox assertion failed");

`endif

FILE: hdl/sbx_pkg.sv
// Package for the AES substitution block: stage type, cell count and GF(2^8) functions.
// Depends on nothing; used by the cell and the top level.
package sbx_pkg;

   localparam int NumCells = 7;
   localparam logic [7:0] AffConst = 8'h63;
   localparam logic [7:0] RedPoly = 8'h1b;
   localparam logic [8:0] FullPoly = 9'h11b;
   localparam logic ModeForward = 1'b0;
   localparam logic ModeInverse = 1'b1;

   typedef struct packed {
      logic       valid;
      logic       mode;
      logic [7:0] sq;
      logic [7:0] acc;
   } stage_type;

   function automatic logic [7:0] gf_xtime(input logic [7:0] a);
      gf_xtime = a[7] ? ({a[6:0], 1'b0} ^ RedPoly) : {a[6:0], 1'b0};
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] f, input logic [7:0] g);
      logic [7:0] h;
      h = 8'h00;
      for (int i = 7; i >= 0; i--) begin
         h = gf_xtime(h);
         if (f[i]) begin
            h = h ^ g;
         end
      end
      gf_mul = h;
   endfunction

   // Squaring is linear over GF(2): spread the bits, then reduce the high half.
   function automatic logic [7:0] gf_sq(input logic [7:0] a);
      logic [14:0] t;
      t = '0;
      for (int i = 0; i < 8; i++) begin
         t[2*i] = a[i];
      end
      for (int k = 14; k >= 8; k--) begin
         if (t[k]) begin
            t = t ^ (15'(FullPoly) << (k - 8));
         end
      end
      gf_sq = t[7:0];
   endfunction

   function automatic logic [7:0] affine_fwd(input logic [7:0] w);
      affine_fwd = w ^ {w[6:0], w[7]} ^ {w[5:0], w[7:6]} ^ {w[4:0], w[7:5]}
                   ^ {w[3:0], w[7:4]} ^ AffConst;
   endfunction

   function automatic logic [7:0] affine_inv(input logic [7:0] y);
      logic [7:0] v;
      v = y ^ AffConst;
      affine_inv = {v[6:0], v[7]} ^ {v[4:0], v[7:5]} ^ {v[1:0], v[7:2]};
   endfunction

endpackage

FILE: hdl/sbx_cell.sv
// One cell of the inversion chain: squares the running power and folds it into the product.
// Depends on sbx_pkg.
module sbx_cell import sbx_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_i,
   output stage_type stage_o
);

   stage_type stage_ff;
   stage_type stage_in;
   logic [7:0] sq_next;

   always_comb begin
      sq_next        = gf_sq(stage_i.sq);
      stage_in.valid = stage_i.valid;
      stage_in.mode  = stage_i.mode;
      stage_in.sq    = sq_next;
      stage_in.acc   = gf_mul(stage_i.acc, sq_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.mode <= stage_in.mode;
      stage_ff.sq   <= stage_in.sq;
      stage_ff.acc  <= stage_in.acc;
   end

   assign stage_o = stage_ff;

endmodule

FILE: hdl/aes_sbox_forward_inverse.sv
// AES substitution byte, forward and inverse, computed as x^254 over a chain of seven cells.
// A word accepted with start passes through the seven cell registers and then the output
// register before it appears on rsp_data_out with rsp_valid; throughput is one word per cycle,
// set by the one-cell-per-cycle chain.
// Synchronous active-high reset clears all valid bits; busy is high only during reset.
// The receiver cannot stall, so results leave the output register unconditionally.
module aes_sbox_forward_inverse import sbx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_mode,
   input  logic [7:0] req_data_in,
   output logic       rsp_valid,
   output logic [7:0] rsp_data_out
);

   `include "aes_sbox_forward_inverse_assert.svh"

   stage_type chain [0:NumCells];
   logic [7:0] field_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_out_ff, rsp_data_out_in;

   assign busy = reset;

   always_comb begin
      field_in          = (req_mode == ModeInverse) ? affine_inv(req_data_in) : req_data_in;
      chain[0].valid    = start && !busy;
      chain[0].mode     = req_mode;
      chain[0].sq       = field_in;
      chain[0].acc      = 8'h01;
   end

   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      sbx_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .stage_i (chain[k]),
         .stage_o (chain[k+1])
      );
   end

   always_comb begin
      rsp_valid_in    = chain[NumCells].valid;
      rsp_data_out_in = (chain[NumCells].mode == ModeInverse) ? chain[NumCells].acc
                                                              : affine_fwd(chain[NumCells].acc);
   end

   always_ff @(posedge clock) begin
      rsp_data_out_ff <= rsp_data_out_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_out_ff;

   `SBX_ASSERT_IMPLIES(a_latency, start && !busy, ##8 rsp_valid)
   `SBX_ASSERT_IMPLIES(a_no_spurious, rsp_valid, $past(start && !busy, 8))
   `SBX_ASSERT_IMPLIES(a_zero_fwd,
      rsp_valid && $past(start && !busy && !req_mode && req_data_in == 8'h00, 8),
      rsp_data_out == AffConst)
   `SBX_ASSERT_NEXT(a_chain_to_out, chain[NumCells].valid, rsp_valid)

endmodule
